// ===== rtl/rhsc_pkg.sv =====
// Shared types, constants and helpers of the RTP hint sample checker.
package rhsc_pkg;

    localparam int unsigned MAX_BUFFER_BYTES = 65536;
    localparam logic [15:0] TLV_SIZE_RESET   = 16'd1000;

    localparam logic [1:0]  RTP_VERSION      = 2'd2;
    localparam logic [15:0] PX_MASK          = 16'h0300;
    localparam logic [15:0] PT_MASK          = 16'h007f;
    localparam logic [15:0] PT_DYN_A         = 16'd96;
    localparam logic [15:0] PT_DYN_B         = 16'd97;
    localparam logic [15:0] FLAGS_MAX        = 16'd7;
    localparam logic [7:0]  MODE_MAX         = 8'd3;
    localparam logic [7:0]  IMM_LEN_MAX      = 8'd14;
    localparam logic [7:0]  AUTOHINT_TRACK   = 8'd255;
    localparam logic [31:0] TLV_HDR_BYTES    = 32'd4;

    localparam logic [3:0]  SCORE_HDR        = 4'd2;
    localparam logic [3:0]  SCORE_PT         = 4'd6;
    localparam logic [3:0]  SCORE_ENTRY      = 4'd6;
    localparam logic [7:0]  SCORE_MAX        = 8'd128;

    // field byte positions
    localparam logic [3:0]  IDX_HDR_END      = 4'd3;
    localparam logic [3:0]  IDX_INFO_END     = 4'd5;
    localparam logic [3:0]  IDX_FLAGS_END    = 4'd9;
    localparam logic [3:0]  IDX_COUNT_END    = 4'd11;
    localparam logic [3:0]  IDX_TLV_END      = 4'd3;
    localparam logic [3:0]  IDX_MODE         = 4'd0;
    localparam logic [3:0]  IDX_TRACK        = 4'd1;
    localparam logic [3:0]  IDX_LEN_END      = 4'd3;
    localparam logic [3:0]  IDX_OFF_END      = 4'd9;
    localparam logic [3:0]  IDX_ENTRY_END    = 4'd15;

    localparam logic [1:0]  MODE_IMM         = 2'd1;
    localparam logic [1:0]  MODE_SAMPLE      = 2'd2;
    localparam logic [1:0]  MODE_DESC        = 2'd3;

    typedef enum logic [1:0] {
        VERD_REJECT = 2'd0,
        VERD_ACCEPT = 2'd1,
        VERD_ENDED  = 2'd2
    } t_verdict;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_HDR   = 6'b000010,
        PH_PKT   = 6'b000100,
        PH_TLVSZ = 6'b001000,
        PH_SKIP  = 6'b010000,
        PH_ENTRY = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [17:0] match_length;
        logic [7:0]  score_exponent;
        t_verdict    verdict;
    } t_result;

    function automatic logic [7:0] sat_add(input logic [7:0] s, input logic [3:0] amt);
        logic [8:0] sum;
        sum = {1'b0, s} + {5'b0, amt};
        return (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[7:0];
    endfunction

endpackage

// ===== rtl/rtp_hint_sample_checker.sv =====
// RTP hint sample checker: byte-stream parser and verdict generator.
// Verdicts: a verdict is registered into the output register, or into the skid register
//   while the output holds a stalled transfer, from the transfer of the byte that decides it;
//   bytes that decide nothing give no result. Throughput: one byte per cycle, sustained as long as results are drained.
// Reset (i_rst_n low at a clock edge) idles the parser, empties the output and skid
//   registers and loads max_tlv_bytes with 1000.
module rtp_hint_sample_checker
    import rhsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: max_tlv_bytes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] data_byte, [24:8] buffer_length, zero fill
    input  logic        s_axis_tlast,   // last_byte
    input  logic [0:0]  s_axis_tuser,   // [0] first_byte
    // verdicts out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] verdict, [9:2] score_exponent,
                                        // [27:10] match_length, zero fill
);

    localparam logic [16:0] MAX_BUF = 17'(MAX_BUFFER_BYTES);

    // configuration register, always writable
    logic [15:0] r_max_tlv;

    // parser state
    t_phase      r_phase,  n_phase;
    logic [3:0]  r_fbi,    n_fbi;
    logic [31:0] r_shift,  n_shift;
    logic [15:0] r_pkts,   n_pkts;
    logic [15:0] r_ents,   n_ents;
    logic [15:0] r_skip,   n_skip;
    logic [1:0]  r_mode,   n_mode;
    logic [7:0]  r_track,  n_track;
    logic [15:0] r_elen,   n_elen;
    logic        r_tlv,    n_tlv;
    logic [7:0]  r_score,  n_score;
    logic [16:0] r_extra,  n_extra;
    logic [16:0] r_bc,     n_bc;
    logic [16:0] r_avail,  n_avail;

    // output register and skid stage
    logic        r_out_valid, r_skid_valid;
    t_result     r_out, r_skid;

    logic        accept;
    logic        pop;
    logic        res_valid;
    t_result     res;

    // combinational step scratch
    logic        active, done, go_afp, go_pd;
    t_verdict    vd;
    logic [3:0]  idx;
    logic [15:0] low16;
    logic [7:0]  b;
    logic [16:0] blen;
    logic [32:0] tlv_reach;
    logic [17:0] reach;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;
    assign b             = s_axis_tdata[7:0];
    assign blen          = s_axis_tdata[24:8];

    always_comb begin
        n_phase = r_phase;  n_fbi   = r_fbi;   n_shift = r_shift;
        n_pkts  = r_pkts;   n_ents  = r_ents;  n_skip  = r_skip;
        n_mode  = r_mode;   n_track = r_track; n_elen  = r_elen;
        n_tlv   = r_tlv;    n_score = r_score; n_extra = r_extra;
        n_bc    = r_bc;     n_avail = r_avail;
        active    = 1'b0;
        done      = 1'b0;
        go_afp    = 1'b0;
        go_pd     = 1'b0;
        vd        = VERD_ENDED;
        idx       = '0;
        low16     = '0;
        tlv_reach = '0;
        reach     = '0;
        res_valid = 1'b0;
        res       = '{match_length: '0, score_exponent: '0, verdict: VERD_ENDED};

        if (accept) begin
            if (s_axis_tuser[0]) begin
                // first byte: drop any open candidate and start over
                n_phase = PH_HDR;  n_fbi   = '0; n_shift = '0;
                n_pkts  = '0;      n_ents  = '0; n_skip  = '0;
                n_mode  = '0;      n_track = '0; n_elen  = '0;
                n_tlv   = 1'b0;    n_score = '0; n_extra = '0;
                n_bc    = '0;
                n_avail = (blen > MAX_BUF) ? MAX_BUF : blen;
                active  = 1'b1;
            end else if (r_phase != PH_IDLE) begin
                active = 1'b1;
            end
        end

        if (active) begin
            if (n_bc >= n_avail) begin
                done = 1'b1;
                vd   = VERD_ENDED;
            end else begin
                n_bc    = n_bc + 17'd1;
                n_shift = {n_shift[23:0], b};
                idx     = n_fbi;
                n_fbi   = idx + 4'd1;
                low16   = n_shift[15:0];

                case (n_phase)
                    PH_HDR: begin
                        if (idx == IDX_HDR_END) begin
                            if (low16 != 16'd0) begin
                                done = 1'b1; vd = VERD_REJECT;
                            end else begin
                                n_pkts = n_shift[31:16];
                                if (n_pkts == 16'd0) begin
                                    done = 1'b1; vd = VERD_ACCEPT;
                                end else begin
                                    n_phase = PH_PKT; n_fbi = '0; n_shift = '0;
                                end
                            end
                        end
                    end
                    PH_PKT: begin
                        if (idx == IDX_INFO_END) begin
                            if (low16[15:14] != RTP_VERSION ||
                                (low16 & PX_MASK) != 16'd0) begin
                                done = 1'b1; vd = VERD_REJECT;
                            end else begin
                                n_score = sat_add(sat_add(n_score, SCORE_HDR), SCORE_HDR);
                                if ((low16 & PT_MASK) == PT_DYN_A ||
                                    (low16 & PT_MASK) == PT_DYN_B) begin
                                    n_score = sat_add(n_score, SCORE_PT);
                                end
                            end
                        end else if (idx == IDX_FLAGS_END) begin
                            if (low16 > FLAGS_MAX) begin
                                done = 1'b1; vd = VERD_REJECT;
                            end else begin
                                n_tlv = low16[2];
                            end
                        end else if (idx == IDX_COUNT_END) begin
                            n_ents = low16;
                            if (n_tlv) begin
                                n_phase = PH_TLVSZ; n_fbi = '0; n_shift = '0;
                            end else begin
                                go_afp = 1'b1;
                            end
                        end
                    end
                    PH_TLVSZ: begin
                        if (idx == IDX_TLV_END) begin
                            // size counts its own field, which started four bytes back
                            tlv_reach = 33'(n_bc) - 33'(TLV_HDR_BYTES) + {1'b0, n_shift};
                            if (n_shift > {16'd0, r_max_tlv} || n_shift < TLV_HDR_BYTES ||
                                tlv_reach > 33'(n_avail)) begin
                                done = 1'b1; vd = VERD_REJECT;
                            end else begin
                                n_skip = n_shift[15:0] - TLV_HDR_BYTES[15:0];
                                if (n_skip == 16'd0) begin
                                    go_afp = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP; n_fbi = '0; n_shift = '0;
                                end
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = n_skip - 16'd1;
                        if (n_skip == 16'd0) begin
                            go_afp = 1'b1;
                        end
                    end
                    PH_ENTRY: begin
                        if (idx == IDX_MODE) begin
                            if (b > MODE_MAX) begin
                                done = 1'b1; vd = VERD_REJECT;
                            end else begin
                                n_mode = b[1:0];
                            end
                        end else if (idx == IDX_TRACK) begin
                            if (n_mode == MODE_IMM && b > IMM_LEN_MAX) begin
                                done = 1'b1; vd = VERD_REJECT;
                            end else begin
                                n_track = b;
                            end
                        end else if (idx == IDX_LEN_END) begin
                            n_elen = low16;
                        end else if (idx == IDX_OFF_END) begin
                            // autohint: signed offset plus length may widen the extent
                            if ((n_mode == MODE_SAMPLE || n_mode == MODE_DESC) &&
                                n_track == AUTOHINT_TRACK) begin
                                reach = {{2{low16[15]}}, low16} + {2'b00, n_elen};
                                if ($signed(reach) > $signed({1'b0, n_extra})) begin
                                    n_extra = reach[16:0];
                                end
                            end
                        end else if (idx == IDX_ENTRY_END) begin
                            n_score = sat_add(n_score, SCORE_ENTRY);
                            n_ents  = n_ents - 16'd1;
                            if (n_ents != 16'd0) begin
                                n_phase = PH_ENTRY; n_fbi = '0; n_shift = '0;
                            end else begin
                                go_pd = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                // fixed part of a packet is over: entries next, or the packet ends
                if (go_afp) begin
                    if (n_ents != 16'd0) begin
                        n_phase = PH_ENTRY; n_fbi = '0; n_shift = '0;
                    end else begin
                        go_pd = 1'b1;
                    end
                end
                if (go_pd) begin
                    n_pkts = n_pkts - 16'd1;
                    if (n_pkts == 16'd0) begin
                        done = 1'b1; vd = VERD_ACCEPT;
                    end else begin
                        n_phase = PH_PKT; n_fbi = '0; n_shift = '0;
                    end
                end

                if (!done && (s_axis_tlast || n_bc >= n_avail)) begin
                    done = 1'b1; vd = VERD_ENDED;
                end
            end

            if (done) begin
                res_valid   = 1'b1;
                res.verdict = vd;
                if (vd == VERD_ACCEPT) begin
                    res.score_exponent = n_score;
                    res.match_length   = 18'(n_bc) + 18'(n_extra);
                end
                n_phase = PH_IDLE; n_fbi = '0; n_shift = '0;
            end
        end
    end

    // parser state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tlv <= TLV_SIZE_RESET;
            r_phase   <= PH_IDLE;
            r_fbi     <= '0;  r_shift <= '0;
            r_pkts    <= '0;  r_ents  <= '0;  r_skip <= '0;
            r_mode    <= '0;  r_track <= '0;  r_elen <= '0;
            r_tlv     <= 1'b0; r_score <= '0; r_extra <= '0;
            r_bc      <= '0;  r_avail <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_tlv <= i_cfg_data;
            end
            r_phase <= n_phase;  r_fbi   <= n_fbi;   r_shift <= n_shift;
            r_pkts  <= n_pkts;   r_ents  <= n_ents;  r_skip  <= n_skip;
            r_mode  <= n_mode;   r_track <= n_track; r_elen  <= n_elen;
            r_tlv   <= n_tlv;    r_score <= n_score; r_extra <= n_extra;
            r_bc    <= n_bc;     r_avail <= n_avail;
        end
    end

    // Output register with one skid entry: a new verdict lands in the skid only
    // when the output holds a stalled transfer; input stalls only while skid is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out};

endmodule

// ===== rtl/rhsc_checker.sv =====
// Port-level assertions for the RTP hint sample checker, bound to the top level.
module rhsc_checker
    import rhsc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata
);

    // hold a stalled verdict unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("verdict transfer changed while stalled");

    // reset empties the output: no verdict is held across reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[1:0] == VERD_REJECT || i_m_tdata[1:0] == VERD_ACCEPT ||
                        i_m_tdata[1:0] == VERD_ENDED) && i_m_tdata[31:28] == 4'd0)
        else $error("bad verdict code or fill bits");

    a_non_accept_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[1:0] != VERD_ACCEPT |-> i_m_tdata[27:2] == 26'd0)
        else $error("score or length set on a non-accept verdict");

    a_score_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[9:2] <= SCORE_MAX)
        else $error("score exponent above saturation");

endmodule

bind rtp_hint_sample_checker rhsc_checker u_rhsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

// ===== tb/sv/rtp_hint_sample_checker_test.sv =====
// Self-checking testbench for the RTP hint sample checker.
`timescale 1ns / 1ps

module rtp_hint_sample_checker_test
    import rhsc_pkg::*;
;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;        // settle time after the last owed verdict; allow margin
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 180;      // least bytes sent in each random phase
    localparam int PHASE_VERDICTS = 2;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the parser state per transfer and holds the
    // verdicts still owed by the block, oldest first.
    // ------------------------------------------------------------------
    class hint_verdict_board;
        logic [15:0] tlv_limit;
        t_phase      phase;
        logic [3:0]  field_idx;
        logic [31:0] shift_word;
        logic [15:0] pkts_left;
        logic [15:0] ents_left;
        logic [15:0] skip_left;
        logic [15:0] ent_len;
        logic [1:0]  ent_mode;
        logic [7:0]  ent_track;
        logic [7:0]  score;
        bit          tlv_on;
        logic [16:0] extent;
        logic [16:0] consumed;
        logic [16:0] avail;
        t_result     pending_verdicts[$];
        int          fails;

        function new();
            tlv_limit = TLV_SIZE_RESET;
            fails = 0;
            drop_candidate();
        endfunction

        function void set_tlv_limit(logic [15:0] v);
            tlv_limit = v;
        endfunction

        function void open_phase(t_phase p);
            phase = p;
            field_idx = '0;
            shift_word = '0;
        endfunction

        function void drop_candidate();
            open_phase(PH_IDLE);
            pkts_left = '0;
            ents_left = '0;
            skip_left = '0;
            ent_len = '0;
            ent_mode = '0;
            ent_track = '0;
            score = '0;
            tlv_on = 1'b0;
            extent = '0;
            consumed = '0;
            avail = '0;
        endfunction

        // Saturate at the maximum exponent, SCORE_MAX.
        function void bump_score(logic [3:0] amt);
            int s;
            s = score + amt;
            score = (s > SCORE_MAX) ? SCORE_MAX : s[7:0];
        endfunction

        function bit packet_end(output t_verdict v);
            v = VERD_ACCEPT;
            pkts_left = pkts_left - 16'd1;
            if (pkts_left == 16'd0) return 1'b1;
            open_phase(PH_PKT);
            return 1'b0;
        endfunction

        function bit fixed_part_end(output t_verdict v);
            v = VERD_ACCEPT;
            if (ents_left != 16'd0) begin
                open_phase(PH_ENTRY);
                return 1'b0;
            end
            return packet_end(v);
        endfunction

        // Advance one field byte; return 1 once a verdict is decided.
        function bit take_byte(logic [7:0] b, logic [3:0] idx, output t_verdict v);
            logic [15:0] low16;
            longint      tlv_len;
            longint      tlv_at;
            int          off;
            int          len;
            int          reach;
            int          ext_now;
            low16 = shift_word[15:0];
            v = VERD_REJECT;
            case (phase)
                PH_HDR: begin
                    if (idx == IDX_HDR_END) begin
                        if (low16 != 16'd0) return 1'b1;
                        pkts_left = shift_word[31:16];
                        if (pkts_left == 16'd0) begin
                            v = VERD_ACCEPT;
                            return 1'b1;
                        end
                        open_phase(PH_PKT);
                    end
                end
                PH_PKT: begin
                    if (idx == IDX_INFO_END) begin
                        if (low16[15:14] != RTP_VERSION) return 1'b1;
                        bump_score(SCORE_HDR);
                        if ((low16 & PX_MASK) != 16'd0) return 1'b1;
                        bump_score(SCORE_HDR);
                        if ((low16 & PT_MASK) == PT_DYN_A || (low16 & PT_MASK) == PT_DYN_B)
                            bump_score(SCORE_PT);
                    end else if (idx == IDX_FLAGS_END) begin
                        if (low16 > FLAGS_MAX) return 1'b1;
                        tlv_on = low16[2];
                    end else if (idx == IDX_COUNT_END) begin
                        ents_left = low16;
                        if (tlv_on) open_phase(PH_TLVSZ);
                        else return fixed_part_end(v);
                    end
                end
                PH_TLVSZ: begin
                    if (idx == IDX_TLV_END) begin
                        // size counts its own four bytes, which started at consumed - 4
                        tlv_len = shift_word;
                        tlv_at = consumed - 17'd4;
                        if (tlv_len > tlv_limit || tlv_len < 4 || tlv_at + tlv_len > avail)
                            return 1'b1;
                        skip_left = 16'(tlv_len - 4);
                        if (skip_left == 16'd0) return fixed_part_end(v);
                        open_phase(PH_SKIP);
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) return fixed_part_end(v);
                end
                PH_ENTRY: begin
                    if (idx == IDX_MODE) begin
                        if (b > MODE_MAX) return 1'b1;
                        ent_mode = b[1:0];
                    end else if (idx == IDX_TRACK) begin
                        if (ent_mode == MODE_IMM && b > IMM_LEN_MAX) return 1'b1;
                        ent_track = b;
                    end else if (idx == IDX_LEN_END) begin
                        ent_len = low16;
                    end else if (idx == IDX_OFF_END) begin
                        // autohint: signed offset plus length may extend the match
                        if ((ent_mode == MODE_SAMPLE || ent_mode == MODE_DESC) &&
                            ent_track == AUTOHINT_TRACK) begin
                            off = $signed(low16);
                            len = ent_len;
                            ext_now = extent;
                            reach = off + len;
                            if (reach > ext_now) extent = reach[16:0];
                        end
                    end else if (idx == IDX_ENTRY_END) begin
                        bump_score(SCORE_ENTRY);
                        ents_left = ents_left - 16'd1;
                        if (ents_left != 16'd0) open_phase(PH_ENTRY);
                        else return packet_end(v);
                    end
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        function void post_verdict(t_verdict v);
            t_result r;
            r.verdict = v;
            if (v == VERD_ACCEPT) begin
                r.score_exponent = score;
                r.match_length = {1'b0, consumed} + {1'b0, extent};
            end else begin
                r.score_exponent = '0;
                r.match_length = '0;
            end
            pending_verdicts.push_back(r);
            open_phase(PH_IDLE);
        endfunction

        // Note one accepted input transfer; return 0 if the block ignores it.
        function bit parse_byte(logic [7:0] b, bit first, bit last, logic [16:0] blen);
            t_verdict   v;
            logic [3:0] idx;
            if (first) begin
                drop_candidate();
                avail = (blen > MAX_BUFFER_BYTES) ? 17'(MAX_BUFFER_BYTES) : blen;
                open_phase(PH_HDR);
            end else if (phase == PH_IDLE) begin
                return 1'b0;
            end
            if (consumed >= avail) begin
                post_verdict(VERD_ENDED);
                return 1'b1;
            end
            consumed = consumed + 17'd1;
            shift_word = {shift_word[23:0], b};
            idx = field_idx;
            field_idx = idx + 4'd1;
            if (take_byte(b, idx, v)) post_verdict(v);
            else if (last || consumed >= avail) post_verdict(VERD_ENDED);
            return 1'b1;
        endfunction

        // Compare one output transfer with the oldest owed verdict.
        function void check_verdict(logic [31:0] word);
            t_result want;
            t_result got;
            if (pending_verdicts.size() == 0) begin
                $error("verdict transfer with nothing owed: %h", word);
                fails++;
                return;
            end
            want = pending_verdicts.pop_front();
            got = t_result'(word[27:0]);
            if (got.verdict != want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                fails++;
            end
            if (got.score_exponent != want.score_exponent) begin
                $error("score_exponent: expected %0d, got %0d",
                       want.score_exponent, got.score_exponent);
                fails++;
            end
            if (got.match_length != want.match_length) begin
                $error("match_length: expected %0d, got %0d",
                       want.match_length, got.match_length);
                fails++;
            end
            if (word[31:28] != 4'd0) begin
                $error("zero_fill: expected 0, got %0h", word[31:28]);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;

    rtp_hint_sample_checker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hint_verdict_board sb = new();

    int         src_idle_pct  = 0;      // chance per cycle that the sender holds off
    int         snk_idle_pct  = 0;      // chance per cycle that the receiver stalls
    int         verdicts_seen = 0;
    int         bytes_sent    = 0;      // every accepted input transfer
    int         cycle_count   = 0;
    logic [7:0] sample_bytes[$];        // candidate under construction

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Receiver back-pressure: one fresh decision per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Monitor: sample both channels on the edge, pre-update values only.
    // Check the output first; a verdict always trails its deciding byte.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_verdict(m_axis_tdata);
                verdicts_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                void'(sb.parse_byte(s_axis_tdata[7:0], s_axis_tuser[0],
                                    s_axis_tlast, s_axis_tdata[24:8]));
                bytes_sent++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void put16(logic [15:0] v);
        sample_bytes.push_back(v[15:8]);
        sample_bytes.push_back(v[7:0]);
    endfunction

    function automatic void put32(logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endfunction

    // Mostly well-formed hint sample with random content; some fields are
    // pushed out of range so each check gets hit.
    function automatic void build_hint_sample(logic [15:0] tlv_limit);
        int          n_pkts;
        int          n_ents;
        int          tlv_len;
        logic [15:0] info;
        logic [15:0] flags;
        logic [7:0]  mode_b;
        logic [7:0]  track_b;
        sample_bytes.delete();
        case ($urandom_range(0, 19))
            0, 1:    n_pkts = 0;
            2, 3, 4: n_pkts = $urandom_range(3, 4);
            default: n_pkts = $urandom_range(1, 2);
        endcase
        put16(16'(n_pkts));
        put16(($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000);
        repeat (n_pkts) begin
            put32($urandom);                            // timestamp
            info = 16'($urandom);
            if ($urandom_range(0, 9) != 0) info[15:14] = RTP_VERSION;
            if ($urandom_range(0, 9) != 0) info[9:8] = 2'b00;
            if ($urandom_range(0, 1) == 0) info[6:0] = 7'($urandom_range(96, 97));
            put16(info);
            put16(16'($urandom));                       // sequence
            flags = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            put16(flags);
            // a few long entry lists drive the score into saturation
            n_ents = ($urandom_range(0, 19) == 0) ? $urandom_range(18, 24)
                                                  : $urandom_range(0, 3);
            put16(16'(n_ents));
            if (flags[2]) begin
                case ($urandom_range(0, 9))
                    0:       tlv_len = $urandom_range(0, 3);
                    1:       tlv_len = tlv_limit;
                    2:       tlv_len = tlv_limit + 1;
                    3:       tlv_len = $urandom;
                    default: tlv_len = $urandom_range(4, 20);
                endcase
                put32(32'(tlv_len));
                if (tlv_len >= 4 && tlv_len <= 64)
                    repeat (tlv_len - 4) sample_bytes.push_back(8'($urandom));
            end
            repeat (n_ents) begin
                mode_b = ($urandom_range(0, 7) != 0) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom_range(4, 255));
                if (mode_b == 8'(MODE_IMM))
                    track_b = ($urandom_range(0, 7) != 0) ? 8'($urandom_range(0, 14))
                                                          : 8'($urandom);
                else
                    track_b = ($urandom_range(0, 1) == 0) ? AUTOHINT_TRACK : 8'($urandom);
                sample_bytes.push_back(mode_b);
                sample_bytes.push_back(track_b);
                put16(16'($urandom));                   // length
                put32($urandom);
                put16(16'($urandom));                   // signed offset
                put32($urandom);
                put16(16'($urandom));
            end
        end
        // occasional corruption
        if ($urandom_range(0, 9) == 0 && sample_bytes.size() > 0)
            sample_bytes[$urandom_range(0, sample_bytes.size() - 1)] = 8'($urandom);
    endfunction

    // Present one byte and hold it until the transfer happens.
    task automatic send_byte(logic [7:0] b, bit first, bit last, logic [16:0] blen);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, blen, b};
        s_axis_tlast  <= last;
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stream the first n_send bytes of the candidate; optionally sprinkle
    // stray restarts into the middle.
    task automatic send_candidate(int blen, int n_send, bit last_at_end, bit stray_first);
        for (int i = 0; i < n_send; i++) begin
            send_byte(sample_bytes[i],
                      (i == 0) || (stray_first && $urandom_range(0, 199) == 0),
                      last_at_end && (i == n_send - 1), 17'(blen));
        end
    endtask

    // Drop valid and wait until no verdict is owed, then let the pipe settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tlv_limit(logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_tlv_limit(v);
    endtask

    // One random candidate: well-formed, pure noise, or cut short.
    task automatic run_random_candidate();
        int kind;
        int blen;
        int n_send;
        kind = $urandom_range(0, 99);
        if (kind < 90) begin
            build_hint_sample(sb.tlv_limit);
        end else begin
            sample_bytes.delete();
            repeat ($urandom_range(1, 24)) sample_bytes.push_back(8'($urandom));
        end
        n_send = (kind >= 80 && kind < 90) ? $urandom_range(1, sample_bytes.size())
                                           : sample_bytes.size();
        case ($urandom_range(0, 9))
            0:       blen = $urandom_range(0, sample_bytes.size());
            1:       blen = MAX_BUFFER_BYTES;
            2:       blen = $urandom_range(0, MAX_BUFFER_BYTES);
            default: blen = sample_bytes.size() + $urandom_range(0, 6);
        endcase
        send_candidate(blen, n_send, $urandom_range(0, 9) < 7, 1'b1);
        // trailing bytes with no start marker: ignored if the parse is closed
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, 1'(($urandom_range(0, 1))), 17'd0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          src_modes[3];
        int          snk_modes[3];
        logic [15:0] limits[6];
        int          start_sent;
        int          start_seen;
        int          n_cands;

        src_modes = '{25, 60, 0};
        snk_modes = '{60, 25, 0};
        limits = '{16'hFFFF, 16'h0000, 16'h0004, 16'h0014,
                   16'($urandom_range(5, 64)), TLV_SIZE_RESET};

        // hold reset, then release
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = src_modes[0];
        snk_idle_pct = snk_modes[0];

        // Directed part, register at its reset value.
        // stray byte while idle: ignored
        send_byte(8'hFF, 1'b0, 1'b0, 17'd0);
        // zero packets: accept right after the four header bytes
        sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_candidate(4, 4, 1'b0, 1'b0);
        // empty buffer: the first byte is already beyond it
        sample_bytes = '{8'h00};
        send_candidate(0, 1, 1'b0, 1'b0);
        // nonzero reserved word, widest buffer: reject
        sample_bytes = '{8'h00, 8'h01, 8'h00, 8'h80};
        send_candidate(MAX_BUFFER_BYTES, 4, 1'b0, 1'b0);
        // input marked as ended mid-header
        sample_bytes = '{8'h00, 8'h02};
        send_candidate(100, 2, 1'b1, 1'b0);
        // open candidate silently restarted by a new start marker
        send_candidate(100, 2, 1'b0, 1'b0);
        sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_candidate(4, 4, 1'b0, 1'b0);
        // all-ones bytes: reserved word fails
        sample_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_candidate(MAX_BUFFER_BYTES, 4, 1'b0, 1'b0);

        // Random part: three idling patterns, two register settings each.
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            src_idle_pct = src_modes[ph / 2];
            snk_idle_pct = snk_modes[ph / 2];
            write_tlv_limit(limits[ph]);
            start_sent = bytes_sent;
            start_seen = verdicts_seen;
            n_cands = 0;
            while (bytes_sent - start_sent < PHASE_BYTES ||
                   verdicts_seen - start_seen < PHASE_VERDICTS) begin
                run_random_candidate();
                n_cands++;
                // hold off the sender until the block has caught up
                if (n_cands == 2) wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rhsc_pkg.sv
rtl/rtp_hint_sample_checker.sv
rtl/rhsc_checker.sv
tb/sv/rtp_hint_sample_checker_test.sv
